// ===== rtl/cssf_pkg.sv =====
package cssf_pkg;

	localparam int TIMER_BITS_DEF = 17;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int ID_W           = 11;
	localparam int LIMIT_W        = 16;

	localparam logic [ID_W-1:0]    DATA_ID_RST   = 11'h100;
	localparam logic [ID_W-1:0]    HB_ID_RST     = 11'h101;
	localparam logic [ID_W-1:0]    GYRO_ID_RST   = 11'h102;
	localparam logic [LIMIT_W-1:0] DATA_LIM_RST  = 16'd2500;
	localparam logic [LIMIT_W-1:0] HB_LIM_RST    = 16'd2500;

	localparam logic [3:0] LEN_AXES   = 4'd7;
	localparam logic [3:0] LEN_HB     = 4'd2;
	localparam logic [7:0] HEALTH_OK  = 8'd1;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DATA_ID   = 3'd0,
		REG_HB_ID     = 3'd1,
		REG_GYRO_ID   = 3'd2,
		REG_DATA_LIM  = 3'd3,
		REG_HB_LIM    = 3'd4
	} cfg_reg_e;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_DATA = 2'd1,
		KIND_HB   = 2'd2,
		KIND_GYRO = 2'd3
	} frame_kind_e;

	typedef struct packed {
		logic       req_type;
		logic [10:0] frame_id;
		logic [3:0] frame_length;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic [7:0] byte_four;
		logic [7:0] byte_five;
		logic [7:0] byte_six;
	} item_t;

	typedef struct packed {
		frame_kind_e        frame_kind;
		logic [7:0]         sequence_value;
		logic               sequence_error;
		logic               sensor_healthy;
		logic               data_recovered;
		logic               heartbeat_recovered;
		logic               data_timeout;
		logic               heartbeat_timeout;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]    data_frame_id;
		logic [ID_W-1:0]    heartbeat_frame_id;
		logic [ID_W-1:0]    gyro_frame_id;
		logic [LIMIT_W-1:0] data_timeout_ticks;
		logic [LIMIT_W-1:0] heartbeat_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] last_sequence;
		logic       sequence_seen;
		logic       data_timed_out;
		logic       heartbeat_seen;
		logic       heartbeat_timed_out;
	} flags_t;

endpackage

// ===== rtl/cssf_eval.sv =====
module cssf_eval #(
	parameter int TIMER_BITS = cssf_pkg::TIMER_BITS_DEF
) (
	input  cssf_pkg::item_t        item,
	input  cssf_pkg::cfg_t         cfg,
	input  cssf_pkg::flags_t       flags,
	input  logic [TIMER_BITS-1:0]  data_elapsed,
	input  logic [TIMER_BITS-1:0]  hb_elapsed,
	output cssf_pkg::result_t      result,
	output cssf_pkg::flags_t       flags_nxt,
	output logic [TIMER_BITS-1:0]  data_elapsed_nxt,
	output logic [TIMER_BITS-1:0]  hb_elapsed_nxt
);

	localparam int CMP_W = (TIMER_BITS > cssf_pkg::LIMIT_W) ? TIMER_BITS : cssf_pkg::LIMIT_W;

	logic is_data;
	logic is_hb;
	logic is_gyro;

	assign is_data = (item.frame_id == cfg.data_frame_id) &&
		(item.frame_length >= cssf_pkg::LEN_AXES);
	assign is_hb   = (item.frame_id == cfg.heartbeat_frame_id) &&
		(item.frame_length >= cssf_pkg::LEN_HB);
	assign is_gyro = (item.frame_id == cfg.gyro_frame_id) &&
		(item.frame_length >= cssf_pkg::LEN_AXES);

	always_comb begin
		result           = '0;
		flags_nxt        = flags;
		data_elapsed_nxt = data_elapsed;
		hb_elapsed_nxt   = hb_elapsed;
		if (item.req_type == cssf_pkg::REQ_FRAME) begin
			if (is_data) begin
				result.frame_kind     = cssf_pkg::KIND_DATA;
				result.sequence_value = item.byte_zero;
				result.sequence_error = flags.sequence_seen &&
					(item.byte_zero != 8'(flags.last_sequence + 8'd1));
				result.data_recovered = flags.data_timed_out;
				flags_nxt.data_timed_out = 1'b0;
				flags_nxt.last_sequence  = item.byte_zero;
				flags_nxt.sequence_seen  = 1'b1;
				data_elapsed_nxt         = '0;
			end else if (is_hb) begin
				result.frame_kind          = cssf_pkg::KIND_HB;
				result.sensor_healthy      = (item.byte_one == cssf_pkg::HEALTH_OK);
				result.heartbeat_recovered = flags.heartbeat_timed_out;
				flags_nxt.heartbeat_timed_out = 1'b0;
				flags_nxt.heartbeat_seen      = 1'b1;
				hb_elapsed_nxt                = '0;
			end else if (is_gyro) begin
				result.frame_kind = cssf_pkg::KIND_GYRO;
			end
			if (is_data || (!is_hb && is_gyro)) begin
				result.axis_x = $signed({item.byte_one, item.byte_two});
				result.axis_y = $signed({item.byte_three, item.byte_four});
				result.axis_z = $signed({item.byte_five, item.byte_six});
			end
		end else begin
			// saturate both timers, then test against the limits
			if (data_elapsed != '1)
				data_elapsed_nxt = data_elapsed + 1'b1;
			if (hb_elapsed != '1)
				hb_elapsed_nxt = hb_elapsed + 1'b1;
			if (flags.sequence_seen && !flags.data_timed_out &&
				(CMP_W'(data_elapsed_nxt) > CMP_W'(cfg.data_timeout_ticks))) begin
				flags_nxt.data_timed_out = 1'b1;
				result.data_timeout      = 1'b1;
			end
			if (flags.heartbeat_seen && !flags.heartbeat_timed_out &&
				(CMP_W'(hb_elapsed_nxt) > CMP_W'(cfg.heartbeat_timeout_ticks))) begin
				flags_nxt.heartbeat_timed_out = 1'b1;
				result.heartbeat_timeout      = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/can_sensor_frame_supervisor_core.sv =====
// Path: an input transfer reaches result valid through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; one item can be
// held in the input register while a finished result waits at the output.
// Reset: arst_n clears config to its defaults, sequence and timeout state, and
// all valid flags; no clearing pass.
module can_sensor_frame_supervisor_core #(
	parameter int TIMER_BITS = cssf_pkg::TIMER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cssf_pkg::item_t                   in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output cssf_pkg::result_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cssf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cssf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                  item_vld_s1;
	cssf_pkg::item_t       item_s1;
	logic                  advance;
	logic                  out_vld_q;
	cssf_pkg::result_t     out_q;
	cssf_pkg::cfg_t        cfg_q;
	cssf_pkg::flags_t      flags_q;
	logic [TIMER_BITS-1:0] data_elapsed_q;
	logic [TIMER_BITS-1:0] hb_elapsed_q;

	cssf_pkg::result_t     result;
	cssf_pkg::flags_t      flags_nxt;
	logic [TIMER_BITS-1:0] data_elapsed_nxt;
	logic [TIMER_BITS-1:0] hb_elapsed_nxt;

	assign advance   = item_vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall  = item_vld_s1 && !advance;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (!in_stall)
				item_vld_s1 <= in_valid;
			if (advance)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (advance)
			out_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_frame_id           <= cssf_pkg::DATA_ID_RST;
			cfg_q.heartbeat_frame_id      <= cssf_pkg::HB_ID_RST;
			cfg_q.gyro_frame_id           <= cssf_pkg::GYRO_ID_RST;
			cfg_q.data_timeout_ticks      <= cssf_pkg::DATA_LIM_RST;
			cfg_q.heartbeat_timeout_ticks <= cssf_pkg::HB_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cssf_pkg::REG_DATA_ID:  cfg_q.data_frame_id <= cfg_data[cssf_pkg::ID_W-1:0];
				cssf_pkg::REG_HB_ID:    cfg_q.heartbeat_frame_id <= cfg_data[cssf_pkg::ID_W-1:0];
				cssf_pkg::REG_GYRO_ID:  cfg_q.gyro_frame_id <= cfg_data[cssf_pkg::ID_W-1:0];
				cssf_pkg::REG_DATA_LIM: cfg_q.data_timeout_ticks <= cfg_data;
				cssf_pkg::REG_HB_LIM:   cfg_q.heartbeat_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// commit supervisor state as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q        <= '0;
			data_elapsed_q <= '0;
			hb_elapsed_q   <= '0;
		end else if (advance) begin
			flags_q        <= flags_nxt;
			data_elapsed_q <= data_elapsed_nxt;
			hb_elapsed_q   <= hb_elapsed_nxt;
		end
	end

	cssf_eval #(
		.TIMER_BITS(TIMER_BITS)
	) u_eval (
		.item             (item_s1),
		.cfg              (cfg_q),
		.flags            (flags_q),
		.data_elapsed     (data_elapsed_q),
		.hb_elapsed       (hb_elapsed_q),
		.result           (result),
		.flags_nxt        (flags_nxt),
		.data_elapsed_nxt (data_elapsed_nxt),
		.hb_elapsed_nxt   (hb_elapsed_nxt)
	);

endmodule

// ===== rtl/cssf_checker.sv =====
module cssf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input cssf_pkg::result_t                 out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_drain_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing two cycles after transfer");

endmodule

bind can_sensor_frame_supervisor_core cssf_checker u_cssf_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cssf_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_IDLE       = 16;
	localparam int MAX_REPORTS    = 10;
	localparam int LONG_RUN_TICKS = 50;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 140;

	localparam logic [3:0]           LEN_MAX         = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	item_t                 in_data;
	logic                  out_valid;
	logic                  out_stall;
	result_t               out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the block's registers and stream state
	cfg_t                      shadow_cfg;
	logic [7:0]                last_seq;
	logic                      seq_seen;
	logic                      data_expired;
	logic                      hb_seen;
	logic                      hb_expired;
	logic [TIMER_BITS_DEF-1:0] data_elapsed;
	logic [TIMER_BITS_DEF-1:0] hb_elapsed;

	result_t pending_results[$];
	int      fail_count  = 0;
	int      cycle_count = 0;
	int      hold_left   = 0;
	int      stall_left  = 0;
	bit      idle_on     = 1'b1;

	can_sensor_frame_supervisor_core #(
		.TIMER_BITS(TIMER_BITS_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("can_sensor_frame_supervisor_core test failed");
			$finish;
		end
	end

	function automatic cfg_t settings(input logic [ID_W-1:0] data_id,
			input logic [ID_W-1:0] hb_id, input logic [ID_W-1:0] gyro_id,
			input logic [LIMIT_W-1:0] data_lim, input logic [LIMIT_W-1:0] hb_lim);
		cfg_t s;
		s.data_frame_id           = data_id;
		s.heartbeat_frame_id      = hb_id;
		s.gyro_frame_id           = gyro_id;
		s.data_timeout_ticks      = data_lim;
		s.heartbeat_timeout_ticks = hb_lim;
		return s;
	endfunction

	// Classify one item, update the stream state and return its result.
	function automatic result_t supervise_item(input item_t it);
		result_t    r;
		logic       axes;
		logic [7:0] next_seq;
		r        = '0;
		axes     = 1'b0;
		next_seq = last_seq + 8'd1;
		if (it.req_type == REQ_FRAME) begin
			if (it.frame_id == shadow_cfg.data_frame_id && it.frame_length >= LEN_AXES) begin
				r.frame_kind     = KIND_DATA;
				r.sequence_value = it.byte_zero;
				r.sequence_error = seq_seen && (it.byte_zero != next_seq);
				r.data_recovered = data_expired;
				data_expired     = 1'b0;
				last_seq         = it.byte_zero;
				seq_seen         = 1'b1;
				data_elapsed     = '0;
				axes             = 1'b1;
			end else if (it.frame_id == shadow_cfg.heartbeat_frame_id &&
					it.frame_length >= LEN_HB) begin
				r.frame_kind          = KIND_HB;
				r.sensor_healthy      = (it.byte_one == HEALTH_OK);
				r.heartbeat_recovered = hb_expired;
				hb_expired            = 1'b0;
				hb_elapsed            = '0;
				hb_seen               = 1'b1;
			end else if (it.frame_id == shadow_cfg.gyro_frame_id &&
					it.frame_length >= LEN_AXES) begin
				r.frame_kind = KIND_GYRO;
				axes         = 1'b1;
			end
			if (axes) begin
				r.axis_x = {it.byte_one, it.byte_two};
				r.axis_y = {it.byte_three, it.byte_four};
				r.axis_z = {it.byte_five, it.byte_six};
			end
		end else begin
			// saturate, then judge each stream against its limit
			if (data_elapsed != '1)
				data_elapsed++;
			if (hb_elapsed != '1)
				hb_elapsed++;
			if (seq_seen && !data_expired && data_elapsed > shadow_cfg.data_timeout_ticks) begin
				data_expired   = 1'b1;
				r.data_timeout = 1'b1;
			end
			if (hb_seen && !hb_expired && hb_elapsed > shadow_cfg.heartbeat_timeout_ticks) begin
				hb_expired          = 1'b1;
				r.heartbeat_timeout = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic item_t make_frame(input logic [ID_W-1:0] id, input logic [3:0] len,
			input logic [7:0] seq, input logic [47:0] payload);
		item_t it;
		it.req_type     = REQ_FRAME;
		it.frame_id     = id;
		it.frame_length = len;
		it.byte_zero    = seq;
		{it.byte_one, it.byte_two, it.byte_three, it.byte_four, it.byte_five,
			it.byte_six} = payload;
		return it;
	endfunction

	function automatic item_t make_tick();
		item_t it;
		it          = '0;
		it.req_type = REQ_TICK;
		return it;
	endfunction

	// Ticks at the given percentage; otherwise mostly well-formed frames for the configured streams, the rest noise.
	function automatic item_t random_item(input int tick_pct);
		item_t it;
		int    pick;
		it.req_type     = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_FRAME;
		it.frame_id     = 11'($urandom);
		it.frame_length = 4'($urandom_range(0, LEN_MAX));
		{it.byte_zero, it.byte_one, it.byte_two, it.byte_three} = $urandom;
		{it.byte_four, it.byte_five, it.byte_six} = 24'($urandom);
		if (it.req_type == REQ_FRAME) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				it.frame_id = shadow_cfg.data_frame_id;
				if (pick < 30)
					it.frame_length = 4'($urandom_range(LEN_AXES, LEN_MAX));
				if ($urandom_range(0, 9) < 8)
					it.byte_zero = last_seq + 8'd1;
			end else if (pick < 60) begin
				it.frame_id = shadow_cfg.heartbeat_frame_id;
				if (pick < 56)
					it.frame_length = 4'($urandom_range(LEN_HB, LEN_MAX));
				if ($urandom_range(0, 2) != 0)
					it.byte_one = HEALTH_OK;
				else if ($urandom_range(0, 1) == 0)
					it.byte_one = '0;
			end else if (pick < 80) begin
				it.frame_id = shadow_cfg.gyro_frame_id;
				if (pick < 76)
					it.frame_length = 4'($urandom_range(LEN_AXES, LEN_MAX));
			end
		end
		return it;
	endfunction

	function automatic cfg_t random_settings(input int phase);
		cfg_t s;
		s = settings(11'($urandom), 11'($urandom), 11'($urandom),
			16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
		if ($urandom_range(0, 3) == 0)
			s.gyro_frame_id = s.heartbeat_frame_id;
		if ($urandom_range(0, 5) == 0)
			s.heartbeat_frame_id = s.data_frame_id;
		if ($urandom_range(0, 7) == 0)
			s.data_timeout_ticks = 16'($urandom);
		if (phase == 1)
			s = settings(11'h7FF, 11'h000, 11'h001, 16'h0000, 16'hFFFF);
		else if (phase == 2)
			s = settings(11'h000, 11'h7FF, 11'h7FE, 16'hFFFF, 16'h0000);
		return s;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Result side: check every transfer, then draw the stall before the next one.
	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("result with nothing pending: %p", out_data);
			end else begin
				want = pending_results.pop_front();
				check_field("frame_kind", 16'(want.frame_kind), 16'(out_data.frame_kind));
				check_field("sequence_value", 16'(want.sequence_value),
					16'(out_data.sequence_value));
				check_field("sequence_error", 16'(want.sequence_error),
					16'(out_data.sequence_error));
				check_field("sensor_healthy", 16'(want.sensor_healthy),
					16'(out_data.sensor_healthy));
				check_field("data_recovered", 16'(want.data_recovered),
					16'(out_data.data_recovered));
				check_field("heartbeat_recovered", 16'(want.heartbeat_recovered),
					16'(out_data.heartbeat_recovered));
				check_field("data_timeout", 16'(want.data_timeout),
					16'(out_data.data_timeout));
				check_field("heartbeat_timeout", 16'(want.heartbeat_timeout),
					16'(out_data.heartbeat_timeout));
				check_field("axis_x", want.axis_x, out_data.axis_x);
				check_field("axis_y", want.axis_y, out_data.axis_y);
				check_field("axis_z", want.axis_z, out_data.axis_z);
			end
			stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Keep valid high across back-to-back items; drop it only for a gap.
	task automatic send_item(input item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(supervise_item(it));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		REG_DATA_ID:  shadow_cfg.data_frame_id           = val[ID_W-1:0];
		REG_HB_ID:    shadow_cfg.heartbeat_frame_id      = val[ID_W-1:0];
		REG_GYRO_ID:  shadow_cfg.gyro_frame_id           = val[ID_W-1:0];
		REG_DATA_LIM: shadow_cfg.data_timeout_ticks      = val[LIMIT_W-1:0];
		REG_HB_LIM:   shadow_cfg.heartbeat_timeout_ticks = val[LIMIT_W-1:0];
		default: ;
		endcase
	endtask

	// Write every register, with junk in the unused ID bits, plus a spare index.
	task automatic apply_settings(input cfg_t s);
		write_reg(REG_DATA_ID, {5'($urandom), s.data_frame_id});
		write_reg(REG_HB_ID, {5'($urandom), s.heartbeat_frame_id});
		write_reg(REG_GYRO_ID, {5'($urandom), s.gyro_frame_id});
		write_reg(REG_DATA_LIM, s.data_timeout_ticks);
		write_reg(REG_HB_LIM, s.heartbeat_timeout_ticks);
		write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_frame_decode();
		send_item(make_tick());
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h00, 48'h7FFF_8000_FFFF));
		send_item(make_frame(DATA_ID_RST, LEN_MAX, 8'h01, 48'h0000_0001_7FFE));
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h07, 48'hA5A5_5A5A_0F0F));
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'hFF, 48'h1234_5678_9ABC));
		send_item(make_frame(DATA_ID_RST, LEN_MAX, 8'h00, 48'hFFFF_FFFF_FFFF));
		send_item(make_frame(DATA_ID_RST, 4'd6, 8'h01, 48'h1111_2222_3333));
		send_item(make_frame(HB_ID_RST, LEN_HB, 8'hFF, 48'h01FF_FFFF_FFFF));
		send_item(make_frame(HB_ID_RST, LEN_MAX, 8'h00, 48'h0000_0000_0000));
		send_item(make_frame(HB_ID_RST, LEN_AXES, 8'h00, 48'hFF00_0000_0000));
		send_item(make_frame(HB_ID_RST, 4'd1, 8'h00, 48'h0100_0000_0000));
		send_item(make_frame(GYRO_ID_RST, LEN_AXES, 8'h55, 48'h8000_7FFF_0000));
		send_item(make_frame(GYRO_ID_RST, 4'd6, 8'h55, 48'h8000_7FFF_0000));
		send_item(make_frame(11'h7FF, LEN_MAX, 8'hFF, 48'hFFFF_FFFF_FFFF));
		send_item(make_frame(11'h000, 4'd0, 8'h00, 48'h0000_0000_0000));
		send_item(make_tick());
	endtask

	task automatic test_id_overlap();
		wait_idle();
		apply_settings(settings(11'h7FF, 11'h7FF, 11'h7FF, DATA_LIM_RST, HB_LIM_RST));
		send_item(make_frame(11'h7FF, LEN_AXES, 8'h01, 48'h0102_0304_0506));
		send_item(make_frame(11'h7FF, 4'd5, 8'h00, 48'h0100_0000_0000));
		send_item(make_frame(11'h7FF, 4'd1, 8'h00, 48'h0100_0000_0000));
		wait_idle();
		apply_settings(settings(11'h000, 11'h555, 11'h555, DATA_LIM_RST, HB_LIM_RST));
		send_item(make_frame(11'h555, LEN_MAX, 8'h00, 48'h0100_0000_0000));
		send_item(make_frame(11'h000, LEN_MAX, 8'h02, 48'hFEDC_BA98_7654));
	endtask

	task automatic test_timeouts();
		wait_idle();
		apply_settings(settings(DATA_ID_RST, HB_ID_RST, GYRO_ID_RST, 16'd0, 16'd2));
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h10, 48'h0));
		send_item(make_frame(HB_ID_RST, LEN_HB, 8'h00, 48'h0100_0000_0000));
		repeat (6) send_item(make_tick());
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h11, 48'h0));
		send_item(make_frame(HB_ID_RST, LEN_HB, 8'h00, 48'h0100_0000_0000));
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h12, 48'h0));
		send_item(make_tick());
	endtask

	// Largest limits: a run of quiet ticks far below the limit raises no timeout.
	task automatic test_long_timeout();
		wait_idle();
		apply_settings(settings(DATA_ID_RST, HB_ID_RST, GYRO_ID_RST, 16'hFFFF, 16'hFFFF));
		idle_on = 1'b0;
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h20, 48'h0));
		send_item(make_frame(HB_ID_RST, LEN_HB, 8'h00, 48'h0100_0000_0000));
		repeat (LONG_RUN_TICKS) send_item(make_tick());
		send_item(make_frame(DATA_ID_RST, LEN_AXES, 8'h21, 48'h0));
		send_item(make_frame(HB_ID_RST, LEN_HB, 8'h00, 48'h0000_0000_0000));
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		wait_idle();
		apply_settings(settings(DATA_ID_RST, HB_ID_RST, GYRO_ID_RST, 16'd3, 16'd5));
		idle_on   = 1'b0;
		hold_left = 120;
		repeat (40) send_item(random_item(50));
		wait_idle();
		repeat (20) send_item(random_item(50));
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int tick_pct;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			apply_settings(random_settings(phase));
			idle_on  = (phase % 4 != 3);
			tick_pct = $urandom_range(20, 80);
			repeat (PHASE_ITEMS) send_item(random_item(tick_pct));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		shadow_cfg   = settings(DATA_ID_RST, HB_ID_RST, GYRO_ID_RST, DATA_LIM_RST, HB_LIM_RST);
		last_seq     = '0;
		seq_seen     = 1'b0;
		data_expired = 1'b0;
		hb_seen      = 1'b0;
		hb_expired   = 1'b0;
		data_elapsed = '0;
		hb_elapsed   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_frame_decode();
		test_id_overlap();
		test_timeouts();
		test_long_timeout();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		fail_count += pending_results.size();
		if (fail_count == 0)
			$display("can_sensor_frame_supervisor_core test passed");
		else
			$display("can_sensor_frame_supervisor_core test failed");
		$finish;
	end

endmodule
